// File: design/uts_pkg.sv
// ----------------------------------------------------------------------------
// uts_pkg
// Shared types, constants and lookup functions for the UTF-8 typographic
// sanitizer: payload structs, sequencer states and the replacement table.
// ----------------------------------------------------------------------------
package uts_pkg;

    // Depth of the trailing whitespace buffer
    localparam int TRAIL_DEPTH = 32;
    localparam int PTR_W = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;
    localparam int CNT_W = $clog2(TRAIL_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // ASCII bytes with special meaning
    localparam logic [7:0] ASCII_TAB    = 8'h09;
    localparam logic [7:0] ASCII_LF     = 8'h0A;
    localparam logic [7:0] ASCII_CR     = 8'h0D;
    localparam logic [7:0] ASCII_SPACE  = 8'h20;
    localparam logic [7:0] ASCII_DEL    = 8'h7F;
    localparam logic [7:0] ASCII_DASH   = 8'h2D;
    localparam logic [7:0] ASCII_DOT    = 8'h2E;
    localparam logic [7:0] ASCII_DQUOTE = 8'h22;
    localparam logic [7:0] ASCII_SQUOTE = 8'h27;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;

    // Whitespace codes kept in the trailing buffer
    localparam logic [1:0] SPC_SPACE = 2'd0;
    localparam logic [1:0] SPC_TAB   = 2'd1;
    localparam logic [1:0] SPC_LF    = 2'd2;
    localparam logic [1:0] SPC_CR    = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_text;
        logic       last_of_run;
    } out_item_t;

    // Up to four text bytes produced by one input byte
    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] bytes;
    } txt_list_t;

    typedef struct packed {
        logic            hit;
        logic [1:0]      len;
        logic [2:0][7:0] rep;
    } subst_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BYTE,
        S_FLUSH,
        S_OVF
    } seq_state_t;

    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == ASCII_SPACE) || (b == ASCII_TAB) ||
                   (b == ASCII_LF) || (b == ASCII_CR);
    endfunction

    function automatic logic [1:0] space_code(input logic [7:0] b);
        case (b)
            ASCII_TAB: space_code = SPC_TAB;
            ASCII_LF:  space_code = SPC_LF;
            ASCII_CR:  space_code = SPC_CR;
            default:   space_code = SPC_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] space_byte(input logic [1:0] code);
        case (code)
            SPC_TAB: space_byte = ASCII_TAB;
            SPC_LF:  space_byte = ASCII_LF;
            SPC_CR:  space_byte = ASCII_CR;
            default: space_byte = ASCII_SPACE;
        endcase
    endfunction

    // Typographic replacement table
    function automatic subst_t subst(input logic [20:0] cp);
        subst_t s;
        s.hit = 1'b1;
        s.len = 2'd0;
        s.rep = '0;
        case (cp)
            21'h0000AD, 21'h00200B, 21'h00200C, 21'h00200D, 21'h00200E,
            21'h00200F, 21'h002028, 21'h002029, 21'h00202A, 21'h00202B,
            21'h00202C, 21'h00202D, 21'h00202E, 21'h002060, 21'h00FEFF,
            21'h002015:
                s.len = 2'd0;
            21'h002010, 21'h002011, 21'h002012, 21'h002013, 21'h002212,
            21'h002022, 21'h002023, 21'h002043, 21'h0025E6:
            begin
                s.len    = 2'd1;
                s.rep[0] = ASCII_DASH;
            end
            21'h002014:
            begin
                s.len    = 2'd2;
                s.rep[0] = ASCII_DASH;
                s.rep[1] = ASCII_DASH;
            end
            21'h002026:
            begin
                s.len    = 2'd3;
                s.rep[0] = ASCII_DOT;
                s.rep[1] = ASCII_DOT;
                s.rep[2] = ASCII_DOT;
            end
            21'h0000A0, 21'h002002, 21'h002003, 21'h002004, 21'h002005,
            21'h002006, 21'h002007, 21'h002008, 21'h002009, 21'h00200A,
            21'h00202F, 21'h00205F, 21'h003000:
            begin
                s.len    = 2'd1;
                s.rep[0] = ASCII_SPACE;
            end
            21'h00201C, 21'h00201D, 21'h00201E, 21'h00201F:
            begin
                s.len    = 2'd1;
                s.rep[0] = ASCII_DQUOTE;
            end
            21'h002018, 21'h002019, 21'h00201A, 21'h00201B, 21'h002032:
            begin
                s.len    = 2'd1;
                s.rep[0] = ASCII_SQUOTE;
            end
            default:
                s.hit = 1'b0;
        endcase
        return s;
    endfunction

endpackage

// File: design/uts_ram.sv
// ----------------------------------------------------------------------------
// uts_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module uts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/uts_decode.sv
// ----------------------------------------------------------------------------
// uts_decode
// UTF-8 decoder: tracks the open sequence and turns each accepted byte into
// a list of zero to four text bytes (passed bytes or a replacement string).
// ----------------------------------------------------------------------------
module uts_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  uts_pkg::in_item_t  item,
    output uts_pkg::txt_list_t list
);

    logic [1:0]      exp_reg,  exp_next;
    logic [20:0]     cp_reg,   cp_next;
    logic [2:0][7:0] held_reg, held_next;
    logic [1:0]      hcnt_reg, hcnt_next;

    logic [7:0]       b;
    logic [20:0]      cp_acc;
    logic             lead;
    uts_pkg::subst_t  sub;

    assign b      = item.in_byte;
    assign cp_acc = {cp_reg[14:0], b[5:0]};
    assign sub    = uts_pkg::subst(cp_acc);

    always_comb
    begin
        exp_next  = exp_reg;
        cp_next   = cp_reg;
        held_next = held_reg;
        hcnt_next = hcnt_reg;
        list      = '0;
        lead      = 1'b1;

        if (exp_reg != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                lead     = 1'b0;
                cp_next  = cp_acc;
                exp_next = exp_reg - 2'd1;
                if (exp_reg == 2'd1)
                begin
                    if (cp_acc == uts_pkg::CP_REPLACEMENT)
                    begin
                        list.cnt = 3'd0;
                    end
                    else if (sub.hit)
                    begin
                        list.cnt      = {1'b0, sub.len};
                        list.bytes[0] = sub.rep[0];
                        list.bytes[1] = sub.rep[1];
                        list.bytes[2] = sub.rep[2];
                    end
                    else
                    begin
                        // replay the held bytes, then this one
                        list.bytes[0]        = held_reg[0];
                        list.bytes[1]        = held_reg[1];
                        list.bytes[2]        = held_reg[2];
                        list.bytes[hcnt_reg] = b;
                        list.cnt             = {1'b0, hcnt_reg} + 3'd1;
                    end
                    hcnt_next = 2'd0;
                    cp_next   = '0;
                end
                else if (hcnt_reg != 2'd3)
                begin
                    held_next[hcnt_reg] = b;
                    hcnt_next           = hcnt_reg + 2'd1;
                end
            end
            else
            begin
                // broken sequence: drop it and decode this byte as a lead
                exp_next  = 2'd0;
                hcnt_next = 2'd0;
                cp_next   = '0;
            end
        end

        if (lead)
        begin
            if (!b[7])
            begin
                if ((b >= uts_pkg::ASCII_SPACE && b != uts_pkg::ASCII_DEL) ||
                    b == uts_pkg::ASCII_TAB || b == uts_pkg::ASCII_LF ||
                    b == uts_pkg::ASCII_CR)
                begin
                    list.cnt      = 3'd1;
                    list.bytes[0] = b;
                end
            end
            else if (b[7:5] == 3'b110)
            begin
                cp_next      = {16'd0, b[4:0]};
                exp_next     = 2'd1;
                held_next[0] = b;
                hcnt_next    = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                cp_next      = {17'd0, b[3:0]};
                exp_next     = 2'd2;
                held_next[0] = b;
                hcnt_next    = 2'd1;
            end
            else if (b[7:3] == 5'b11110)
            begin
                cp_next      = {18'd0, b[2:0]};
                exp_next     = 2'd3;
                held_next[0] = b;
                hcnt_next    = 2'd1;
            end
        end

        if (item.text_end)
        begin
            exp_next  = 2'd0;
            cp_next   = '0;
            hcnt_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg  <= 2'd0;
            cp_reg   <= '0;
            hcnt_reg <= 2'd0;
        end
        else if (take)
        begin
            exp_reg  <= exp_next;
            cp_reg   <= cp_next;
            hcnt_reg <= hcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            held_reg <= held_next;
        end
    end

endmodule

// File: design/utf8_typographic_sanitizer.sv
// ----------------------------------------------------------------------------
// utf8_typographic_sanitizer
// Byte-stream UTF-8 sanitizer: drops controls and malformed sequences,
// replaces typographic codepoints, trims leading and trailing whitespace.
// ----------------------------------------------------------------------------
// Path: an input byte's text list is registered; each result then waits in the
//   staging slot until the next result or the run's end, then the output register.
// Flow: a new input byte is taken only after every text byte, flushed whitespace
//   byte, buffer read (flush start or overflow) and end marker of the last one
//   is done; the buffer RAM read port sets the flush pace.
// Reset: rst_n clears all control state at once; the whitespace RAM is not
//   cleared (entries are always written before they are read).
// ----------------------------------------------------------------------------
module utf8_typographic_sanitizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_ready,
    input  uts_pkg::in_item_t  text_item,
    output logic               clean_valid,
    input  logic               clean_ready,
    output uts_pkg::out_item_t clean_item
);

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    uts_pkg::seq_state_t           st_reg,   st_next;
    uts_pkg::txt_list_t            list_reg, list_next;
    logic [2:0]                    idx_reg,  idx_next;
    logic                          end_reg,  end_next;
    logic                          seen_reg, seen_next;
    logic [uts_pkg::PTR_W-1:0]     head_reg, head_next;
    logic [uts_pkg::CNT_W-1:0]     pcnt_reg, pcnt_next;

    // Staging slot: holds the newest result until we know if it closes the run
    logic                          stg_valid_reg, stg_valid_next;
    uts_pkg::out_item_t            stg_reg,       stg_next;
    logic                          out_valid_reg, out_valid_next;
    uts_pkg::out_item_t            out_reg,       out_next;

    // Decoder
    logic                          take;
    uts_pkg::txt_list_t            dec_list;

    // Whitespace buffer RAM
    logic                          ram_we;
    logic [uts_pkg::PTR_W-1:0]     ram_waddr;
    logic [1:0]                    ram_wdata;
    logic                          ram_re;
    logic [uts_pkg::PTR_W-1:0]     ram_raddr;
    logic [1:0]                    ram_rdata;

    // Helpers
    logic [7:0]                    cur_byte;
    logic [uts_pkg::SUM_W-1:0]     tail_sum;
    logic [uts_pkg::PTR_W-1:0]     tail_ptr;
    logic [uts_pkg::PTR_W-1:0]     head_inc;
    logic                          out_free;
    logic                          can_prod;
    logic                          fin_ok;
    logic                          produce;
    uts_pkg::out_item_t            prod_item;
    logic                          finalize;

    assign take = text_valid && text_ready;

    uts_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (text_item),
        .list  (dec_list)
    );

    uts_ram #(
        .WIDTH (2),
        .DEPTH (uts_pkg::TRAIL_DEPTH)
    ) u_trail_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur_byte = list_reg.bytes[idx_reg[1:0]];

    // Tail of the circular buffer: head + count, wrapped once
    always_comb
    begin
        tail_sum = uts_pkg::SUM_W'(head_reg) + uts_pkg::SUM_W'(pcnt_reg);
        if (tail_sum >= uts_pkg::SUM_W'(uts_pkg::TRAIL_DEPTH))
        begin
            tail_sum = tail_sum - uts_pkg::SUM_W'(uts_pkg::TRAIL_DEPTH);
        end
        tail_ptr = tail_sum[uts_pkg::PTR_W-1:0];
    end

    assign head_inc = (head_reg == uts_pkg::PTR_W'(uts_pkg::TRAIL_DEPTH - 1)) ?
                      '0 : head_reg + uts_pkg::PTR_W'(1);

    assign out_free = !out_valid_reg || clean_ready;
    assign can_prod = !stg_valid_reg || out_free;

    // Run is complete when the list is consumed, no end marker is owed and the staged result can move out
    assign fin_ok = (st_reg == uts_pkg::S_BYTE) && (idx_reg == list_reg.cnt) &&
                    !end_reg && (!stg_valid_reg || out_free);

    assign text_ready = (st_reg == uts_pkg::S_IDLE) || fin_ok;

    // ------------------------------------------------------------------
    // Next state and datapath control
    // ------------------------------------------------------------------
    always_comb
    begin
        st_next   = st_reg;
        list_next = list_reg;
        idx_next  = idx_reg;
        end_next  = end_reg;
        seen_next = seen_reg;
        head_next = head_reg;
        pcnt_next = pcnt_reg;

        ram_we    = 1'b0;
        ram_waddr = tail_ptr;
        ram_wdata = uts_pkg::space_code(cur_byte);
        ram_re    = 1'b0;
        ram_raddr = head_reg;

        produce   = 1'b0;
        prod_item = '0;
        finalize  = 1'b0;

        case (st_reg)
            uts_pkg::S_IDLE:
            begin
                if (take)
                begin
                    list_next = dec_list;
                    idx_next  = 3'd0;
                    end_next  = text_item.text_end;
                    st_next   = uts_pkg::S_BYTE;
                end
            end

            uts_pkg::S_BYTE:
            begin
                if (idx_reg == list_reg.cnt)
                begin
                    if (end_reg)
                    begin
                        // end of text: emit the marker, discard held whitespace
                        if (can_prod)
                        begin
                            produce               = 1'b1;
                            prod_item.end_of_text = 1'b1;
                            end_next              = 1'b0;
                            seen_next             = 1'b0;
                            pcnt_next             = '0;
                            head_next             = '0;
                        end
                    end
                    else if (fin_ok)
                    begin
                        finalize = 1'b1;
                        if (take)
                        begin
                            list_next = dec_list;
                            idx_next  = 3'd0;
                            end_next  = text_item.text_end;
                        end
                        else
                        begin
                            st_next = uts_pkg::S_IDLE;
                        end
                    end
                end
                else if (uts_pkg::is_space(cur_byte))
                begin
                    if (!seen_reg)
                    begin
                        // drop leading whitespace
                        idx_next = idx_reg + 3'd1;
                    end
                    else if (pcnt_reg == uts_pkg::CNT_W'(uts_pkg::TRAIL_DEPTH))
                    begin
                        // buffer full: fetch the oldest entry to emit it
                        ram_re  = 1'b1;
                        st_next = uts_pkg::S_OVF;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        pcnt_next = pcnt_reg + uts_pkg::CNT_W'(1);
                        idx_next  = idx_reg + 3'd1;
                    end
                end
                else if (pcnt_reg != '0)
                begin
                    // non-space byte: flush the held whitespace first
                    ram_re  = 1'b1;
                    st_next = uts_pkg::S_FLUSH;
                end
                else if (can_prod)
                begin
                    produce              = 1'b1;
                    prod_item.out_byte   = cur_byte;
                    prod_item.byte_valid = 1'b1;
                    seen_next            = 1'b1;
                    idx_next             = idx_reg + 3'd1;
                end
            end

            uts_pkg::S_FLUSH:
            begin
                if (can_prod)
                begin
                    produce              = 1'b1;
                    prod_item.out_byte   = uts_pkg::space_byte(ram_rdata);
                    prod_item.byte_valid = 1'b1;
                    head_next            = head_inc;
                    pcnt_next            = pcnt_reg - uts_pkg::CNT_W'(1);
                    if (pcnt_reg == uts_pkg::CNT_W'(1))
                    begin
                        st_next = uts_pkg::S_BYTE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = head_inc;
                    end
                end
            end

            uts_pkg::S_OVF:
            begin
                if (can_prod)
                begin
                    // emit the oldest, store the new code in its slot
                    produce              = 1'b1;
                    prod_item.out_byte   = uts_pkg::space_byte(ram_rdata);
                    prod_item.byte_valid = 1'b1;
                    ram_we               = 1'b1;
                    ram_waddr            = head_reg;
                    head_next            = head_inc;
                    idx_next             = idx_reg + 3'd1;
                    st_next              = uts_pkg::S_BYTE;
                end
            end

            default:
            begin
                st_next = uts_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Staging slot and output register
    // ------------------------------------------------------------------
    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        stg_next       = stg_reg;
        out_valid_next = out_valid_reg && !clean_ready;
        out_next       = out_reg;

        if (produce)
        begin
            // a newer result exists, so the staged one is not last
            if (stg_valid_reg)
            begin
                out_valid_next       = 1'b1;
                out_next             = stg_reg;
                out_next.last_of_run = 1'b0;
            end
            stg_valid_next = 1'b1;
            stg_next       = prod_item;
        end
        else if (finalize && stg_valid_reg)
        begin
            out_valid_next       = 1'b1;
            out_next             = stg_reg;
            out_next.last_of_run = 1'b1;
            stg_valid_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= uts_pkg::S_IDLE;
            idx_reg       <= 3'd0;
            end_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            head_reg      <= '0;
            pcnt_reg      <= '0;
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            idx_reg       <= idx_next;
            end_reg       <= end_next;
            seen_reg      <= seen_next;
            head_reg      <= head_next;
            pcnt_reg      <= pcnt_next;
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        list_reg <= list_next;
        stg_reg  <= stg_next;
        out_reg  <= out_next;
    end

    assign clean_valid = out_valid_reg;
    assign clean_item  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == uts_pkg::S_FLUSH) |-> (pcnt_reg != '0))
        else $error("flush running with empty whitespace buffer");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == uts_pkg::S_OVF) |->
            (pcnt_reg == uts_pkg::CNT_W'(uts_pkg::TRAIL_DEPTH)))
        else $error("overflow path taken with buffer not full");

    a_idle_stage_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == uts_pkg::S_IDLE) |-> !stg_valid_reg)
        else $error("result left in staging slot after run closed");

    a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (clean_valid && clean_item.end_of_text) |->
            (clean_item.last_of_run && !clean_item.byte_valid))
        else $error("end marker not closing its run");

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 typographic sanitizer. Drives byte
// transfers under random idling and back-pressure, predicts every output
// transfer in a scoreboard and compares results field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int END_TAIL       = 20;    // quiet cycles after the last result

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the decoder and whitespace trimmer state, plus
    // the queue of output transfers still owed by the block.
    // ------------------------------------------------------------------------
    class sanitizer_scoreboard;

        uts_pkg::out_item_t expected_q[$];
        uts_pkg::out_item_t step_q[$];

        int unsigned need_cnt;
        logic [20:0] cp_acc;
        logic [7:0]  held [3];
        int unsigned held_cnt;
        bit          seen_text;
        logic [7:0]  blank_q[$];

        int          mismatch_count;
        int          result_count;
        int          input_count;
        int          text_count;

        function new();
            clear_state();
            mismatch_count = 0;
            result_count   = 0;
            input_count    = 0;
            text_count     = 0;
        endfunction

        function void clear_state();
            need_cnt  = 0;
            cp_acc    = '0;
            held_cnt  = 0;
            seen_text = 1'b0;
            blank_q.delete();
        endfunction

        function void add_result(logic [7:0] b, logic v, logic e);
            uts_pkg::out_item_t r;
            r.out_byte    = b;
            r.byte_valid  = v;
            r.end_of_text = e;
            r.last_of_run = 1'b0;
            step_q.insert(step_q.size(), r);
        endfunction

        function bit is_blank(logic [7:0] c);
            return (c == uts_pkg::ASCII_SPACE) || (c == uts_pkg::ASCII_TAB) ||
                   (c == uts_pkg::ASCII_LF) || (c == uts_pkg::ASCII_CR);
        endfunction

        // Trim leading blanks, hold trailing ones, release them before text.
        function void text_out(logic [7:0] c);
            if (is_blank(c))
            begin
                if (!seen_text)
                    return;
                if (blank_q.size() >= uts_pkg::TRAIL_DEPTH)
                    add_result(blank_q.pop_front(), 1'b1, 1'b0);
                blank_q.insert(blank_q.size(), c);
                return;
            end
            foreach (blank_q[k])
                add_result(blank_q[k], 1'b1, 1'b0);
            blank_q.delete();
            add_result(c, 1'b1, 1'b0);
            seen_text = 1'b1;
        endfunction

        // Replacement string for a typographic codepoint; -1 keeps the bytes.
        function int typo_string(logic [20:0] cp, output logic [7:0] s [3]);
            s[0] = uts_pkg::ASCII_SPACE;
            s[1] = uts_pkg::ASCII_SPACE;
            s[2] = uts_pkg::ASCII_SPACE;
            case (cp)
                21'h0000AD, 21'h00200B, 21'h00200C, 21'h00200D, 21'h00200E,
                21'h00200F, 21'h002028, 21'h002029, 21'h00202A, 21'h00202B,
                21'h00202C, 21'h00202D, 21'h00202E, 21'h002060, 21'h00FEFF,
                21'h002015:
                    return 0;
                21'h002010, 21'h002011, 21'h002012, 21'h002013, 21'h002212,
                21'h002022, 21'h002023, 21'h002043, 21'h0025E6:
                begin
                    s[0] = uts_pkg::ASCII_DASH;
                    return 1;
                end
                21'h002014:
                begin
                    s[0] = uts_pkg::ASCII_DASH;
                    s[1] = uts_pkg::ASCII_DASH;
                    return 2;
                end
                21'h002026:
                begin
                    s[0] = uts_pkg::ASCII_DOT;
                    s[1] = uts_pkg::ASCII_DOT;
                    s[2] = uts_pkg::ASCII_DOT;
                    return 3;
                end
                21'h0000A0, 21'h002002, 21'h002003, 21'h002004, 21'h002005,
                21'h002006, 21'h002007, 21'h002008, 21'h002009, 21'h00200A,
                21'h00202F, 21'h00205F, 21'h003000:
                    return 1;
                21'h00201C, 21'h00201D, 21'h00201E, 21'h00201F:
                begin
                    s[0] = uts_pkg::ASCII_DQUOTE;
                    return 1;
                end
                21'h002018, 21'h002019, 21'h00201A, 21'h00201B, 21'h002032:
                begin
                    s[0] = uts_pkg::ASCII_SQUOTE;
                    return 1;
                end
                default:
                    return -1;
            endcase
        endfunction

        function void close_codepoint(logic [20:0] cp, logic [7:0] last_b);
            logic [7:0] s [3];
            int         len;
            if (cp == uts_pkg::CP_REPLACEMENT)
                return;
            len = typo_string(cp, s);
            if (len >= 0)
            begin
                for (int k = 0; k < len; k++)
                    text_out(s[k]);
                return;
            end
            for (int k = 0; k < held_cnt; k++)
                text_out(held[k]);
            text_out(last_b);
        endfunction

        // Predict all results caused by one accepted input transfer.
        function void note_input(uts_pkg::in_item_t it);
            logic [7:0]  b;
            bit          as_lead;
            int unsigned need;
            b       = it.in_byte;
            as_lead = 1'b1;
            need    = 0;
            step_q.delete();
            input_count++;

            if (need_cnt > 0)
            begin
                if (b[7:6] == 2'b10)
                begin
                    as_lead  = 1'b0;
                    cp_acc   = {cp_acc[14:0], b[5:0]};
                    need_cnt = need_cnt - 1;
                    if (need_cnt == 0)
                    begin
                        close_codepoint(cp_acc, b);
                        held_cnt = 0;
                        cp_acc   = '0;
                    end
                    else if (held_cnt < 3)
                    begin
                        held[held_cnt] = b;
                        held_cnt++;
                    end
                end
                else
                begin
                    // broken sequence: drop it and decode this byte afresh
                    need_cnt = 0;
                    held_cnt = 0;
                    cp_acc   = '0;
                end
            end

            if (as_lead)
            begin
                if (!b[7])
                begin
                    if ((b >= uts_pkg::ASCII_SPACE && b < uts_pkg::ASCII_DEL) ||
                        b == uts_pkg::ASCII_TAB || b == uts_pkg::ASCII_LF ||
                        b == uts_pkg::ASCII_CR)
                        text_out(b);
                end
                else if (b[7:5] == 3'b110)
                begin
                    cp_acc = {16'd0, b[4:0]};
                    need   = 1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    cp_acc = {17'd0, b[3:0]};
                    need   = 2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    cp_acc = {18'd0, b[2:0]};
                    need   = 3;
                end
                if (need > 0)
                begin
                    need_cnt = need;
                    held[0]  = b;
                    held_cnt = 1;
                end
            end

            if (it.text_end)
            begin
                clear_state();
                add_result(8'h00, 1'b0, 1'b1);
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last_of_run = 1'b1;
            foreach (step_q[k])
                expected_q.insert(expected_q.size(), step_q[k]);
        endfunction

        task flag_mismatch(string msg);
            if (mismatch_count < 40)
                $display("MISMATCH: %s", msg);
            mismatch_count++;
        endtask

        task check_result(uts_pkg::out_item_t got);
            uts_pkg::out_item_t want;
            result_count++;
            if (expected_q.size() == 0)
            begin
                flag_mismatch($sformatf("result %0d (byte %02h) with nothing expected",
                                        result_count, got.out_byte));
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte)
                flag_mismatch($sformatf("result %0d out_byte %02h, want %02h",
                                        result_count, got.out_byte, want.out_byte));
            if (got.byte_valid !== want.byte_valid)
                flag_mismatch($sformatf("result %0d byte_valid %b, want %b",
                                        result_count, got.byte_valid, want.byte_valid));
            if (got.end_of_text !== want.end_of_text)
                flag_mismatch($sformatf("result %0d end_of_text %b, want %b",
                                        result_count, got.end_of_text, want.end_of_text));
            if (got.last_of_run !== want.last_of_run)
                flag_mismatch($sformatf("result %0d last_of_run %b, want %b",
                                        result_count, got.last_of_run, want.last_of_run));
            if (want.end_of_text)
                text_count++;
        endtask

    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block under test
    // ------------------------------------------------------------------------
    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               text_valid  = 1'b0;
    logic               text_ready;
    uts_pkg::in_item_t  text_item   = '0;
    logic               clean_valid;
    logic               clean_ready = 1'b0;
    uts_pkg::out_item_t clean_item;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    utf8_typographic_sanitizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_item   (text_item),
        .clean_valid (clean_valid),
        .clean_ready (clean_ready),
        .clean_item  (clean_item)
    );

    sanitizer_scoreboard sb;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request  = 1'b0;
    int bytes_sent    = 0;
    int stall_cycles  = 0;

    // Every listed typographic codepoint, plus the replacement character.
    logic [20:0] typo_cps [0:49] = '{
        21'h0000AD, 21'h00200B, 21'h00200C, 21'h00200D, 21'h00200E,
        21'h00200F, 21'h002028, 21'h002029, 21'h00202A, 21'h00202B,
        21'h00202C, 21'h00202D, 21'h00202E, 21'h002060, 21'h00FEFF,
        21'h002015, 21'h002010, 21'h002011, 21'h002012, 21'h002013,
        21'h002212, 21'h002022, 21'h002023, 21'h002043, 21'h0025E6,
        21'h002014, 21'h002026, 21'h0000A0, 21'h002002, 21'h002003,
        21'h002004, 21'h002005, 21'h002006, 21'h002007, 21'h002008,
        21'h002009, 21'h00200A, 21'h00202F, 21'h00205F, 21'h003000,
        21'h00201C, 21'h00201D, 21'h00201E, 21'h00201F, 21'h002018,
        21'h002019, 21'h00201A, 21'h00201B, 21'h002032, 21'h00FFFD
    };

    // ------------------------------------------------------------------------
    // Monitor: note input transfers, check output transfers and watch for a
    // hang. All reads happen at the edge, so they see pre-edge values.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_valid && text_ready)
                sb.note_input(text_item);
            if (clean_valid && clean_ready)
                sb.check_result(clean_item);
            if ((text_valid && text_ready) || (clean_valid && clean_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Watchdog: no transfer for %0d cycles", stall_cycles);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure; on request, hold ready low for a long
    // stretch so the block fills up and stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                clean_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            clean_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one byte; idle first at random, then hold valid until the transfer.
    task automatic send_byte(input logic [7:0] b, input logic e);
        uts_pkg::in_item_t it;
        int                gap;
        gap = 0;
        while (int'($urandom_range(99)) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.in_byte  = b;
        it.text_end = e;
        text_item  <= it;
        text_valid <= 1'b1;
        do
            @(posedge clk);
        while (!text_ready);
        bytes_sent++;
    endtask

    function automatic int min_len(input logic [20:0] cp);
        if (cp < 21'h80)
            return 1;
        if (cp < 21'h800)
            return 2;
        if (cp < 21'h10000)
            return 3;
        return 4;
    endfunction

    // Encode cp in len bytes (longer than needed gives an overlong form).
    task automatic send_cp(input logic [20:0] cp, input int len, input bit close);
        logic [7:0] seq [4];
        case (len)
            1: seq[0] = {1'b0, cp[6:0]};
            2:
            begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int k = 0; k < len; k++)
            send_byte(seq[k], close && (k == len - 1));
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0:       return uts_pkg::ASCII_SPACE;
            1:       return uts_pkg::ASCII_TAB;
            2:       return uts_pkg::ASCII_LF;
            default: return uts_pkg::ASCII_CR;
        endcase
    endfunction

    task automatic send_blank_run(input int n, input bit close);
        for (int k = 0; k < n; k++)
            send_byte(pick_blank(), close && (k == n - 1));
    endtask

    // One random token: mostly well-formed text, some broken input and noise.
    task automatic send_token(input bit close);
        int          kind;
        int          len;
        int          conts;
        logic [20:0] cp;
        kind = int'($urandom_range(99));
        if (kind < 30)
        begin
            send_byte(8'($urandom_range(8'h21, 8'h7E)), close);
        end
        else if (kind < 44)
        begin
            send_blank_run(int'($urandom_range(1, 4)), close);
        end
        else if (kind < 47)
        begin
            // long enough to overflow the trailing buffer now and then
            send_blank_run(int'($urandom_range(uts_pkg::TRAIL_DEPTH - 4,
                                               uts_pkg::TRAIL_DEPTH + 8)), close);
        end
        else if (kind < 69)
        begin
            cp = typo_cps[$urandom_range(49)];
            send_cp(cp, min_len(cp), close);
        end
        else if (kind < 79)
        begin
            case ($urandom_range(2))
                0:       cp = 21'($urandom_range(21'h80, 21'h7FF));
                1:       cp = 21'($urandom_range(21'h800, 21'hFFFF));
                default: cp = 21'($urandom_range(21'h10000, 21'h1FFFFF));
            endcase
            send_cp(cp, min_len(cp), close);
        end
        else if (kind < 83)
        begin
            // overlong form; its decoded value is still looked up in the replacement table
            cp = ($urandom_range(1) == 0) ? 21'hA0 : 21'($urandom_range(0, 21'h7FF));
            send_cp(cp, int'($urandom_range(min_len(cp) + 1, 4)), close);
        end
        else if (kind < 89)
        begin
            // truncated sequence, cut by a new lead or closed by end of text
            len   = int'($urandom_range(2, 4));
            conts = int'($urandom_range(0, len - 2));
            case (len)
                2:       send_byte(8'($urandom_range(8'hC0, 8'hDF)), close && conts == 0);
                3:       send_byte(8'($urandom_range(8'hE0, 8'hEF)), close && conts == 0);
                default: send_byte(8'($urandom_range(8'hF0, 8'hF7)), close && conts == 0);
            endcase
            for (int k = 0; k < conts; k++)
                send_byte(8'($urandom_range(8'h80, 8'hBF)), close && (k == conts - 1));
            if (!close)
            begin
                if ($urandom_range(1) == 0)
                    send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
                else
                    send_byte(8'($urandom_range(8'hC0, 8'hFF)), 1'b0);
            end
        end
        else if (kind < 94)
        begin
            if ($urandom_range(1) == 0)
                send_byte(8'($urandom_range(8'h80, 8'hBF)), close);
            else
                send_byte(8'($urandom_range(8'hF8, 8'hFF)), close);
        end
        else
        begin
            send_byte(8'($urandom_range(0, 255)), close);
        end
    endtask

    // Random texts, closed now and then; always close the last one.
    task automatic random_text(input int count);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < count)
            send_token($urandom_range(24) == 0);
        send_byte(8'($urandom_range(8'h21, 8'h7E)), 1'b1);
    endtask

    // Pause the sender until every predicted result has come out.
    task automatic wait_drain();
        text_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_q.size() != 0);
    endtask

    task automatic directed_part();
        send_byte(uts_pkg::ASCII_SPACE, 1'b0);  // leading blanks: trimmed
        send_byte(uts_pkg::ASCII_TAB, 1'b0);
        send_byte(8'h00, 1'b0);                 // control: dropped
        send_byte(uts_pkg::ASCII_DEL, 1'b0);    // DEL: dropped
        send_byte(8'h41, 1'b0);
        send_byte(uts_pkg::ASCII_SPACE, 1'b0);  // held, then released before text
        send_byte(8'h7E, 1'b0);
        send_cp(21'h002014, 3, 1'b0);           // em dash
        send_cp(21'h002026, 3, 1'b0);           // ellipsis
        send_cp(21'h0000A0, 2, 1'b0);           // no-break space, becomes a held blank
        send_cp(21'h00FFFD, 3, 1'b0);           // replacement character: dropped
        send_cp(21'h01F600, 4, 1'b0);           // four-byte codepoint passes as is
        send_byte(8'hE2, 1'b0);                 // broken sequence, breaker re-decoded
        send_byte(8'h41, 1'b0);
        send_byte(8'h80, 1'b0);                 // stray continuation
        send_byte(8'hFF, 1'b0);                 // invalid lead
        send_byte(uts_pkg::ASCII_CR, 1'b0);     // trailing blank, discarded at end
        send_byte(8'hC3, 1'b1);                 // unfinished sequence at end of text
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: light sender idling, heavy receiver back-pressure.
        send_idle_pct = 16;
        recv_idle_pct = 51;
        directed_part();
        wait_drain();

        // Overflow the trailing buffer, with a long hold-off on the output.
        hold_request = 1'b1;
        send_byte(8'h78, 1'b0);
        send_blank_run(uts_pkg::TRAIL_DEPTH + 8, 1'b0);
        send_byte(8'h79, 1'b0);
        random_text(45);
        wait_drain();

        // Phase 2: roles swapped.
        send_idle_pct = 51;
        recv_idle_pct = 16;
        random_text(45);
        wait_drain();

        // Phase 3: no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_text(45);
        wait_drain();

        // Let any stray output show up before the verdict.
        repeat (END_TAIL) @(posedge clk);

        $display("Sent %0d bytes, checked %0d results over %0d texts, %0d mismatches.",
                 sb.input_count, sb.result_count, sb.text_count, sb.mismatch_count);
        $display("Covered replacements, malformed and overlong input, buffer overflow, stalls.");
        if (sb.mismatch_count == 0 && sb.expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
